>>> hdl/vca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vca_pkg
// Shared types for the candle aggregator: queued command and queue status.
// ----------------------------------------------------------------------------
package vca_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned PRICE_W = 32;
  localparam int unsigned AMT_W   = 32;
  localparam int unsigned VSUM_W  = 64;
  localparam int unsigned ASUM_W  = 48;

  // Work handed from the front to the back
  typedef enum logic [1:0] {
    CMD_ACC        = 2'd0,  // add a trade to the open period
    CMD_OPEN       = 2'd1,  // open a period with this trade
    CMD_CLOSE      = 2'd2,  // close the open period (flush)
    CMD_CLOSE_OPEN = 2'd3   // close the open period, then open a new one
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [KEY_W-1:0]    key;
    logic [PRICE_W-1:0]  price;
    logic [AMT_W-1:0]    amount;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage : vca_pkg
`default_nettype wire

>>> hdl/vwap_candle_aggregator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vwap_candle_aggregator
// Builds volume-weighted candles from a stream of trade entries.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one entry per transfer. in_operation 0 is
// a trade (period key, Q16.16 price and amount), 1 flushes the open period.
// Output channel (out_valid/out_ready): one candle per transfer with key,
// high, low, open (previous close), close (VWAP) and a zero-volume flag.
// The front takes an entry in every cycle while the command queue has room
// (FIFO_DEPTH entries); a flush with no open period is dropped there.
// The back drains the queue one command at a time:
//   trade in the same period or opening a period: dispatch,
//     32x32 multiply, saturating add;
//   period close: dispatch, the one-bit-per-cycle divider, emit;
//     the divider is skipped when the period has zero volume, and the
//     multiply and add follow when the close also opens the next period.
// The first closed period only sets the open price and emits nothing.
// A stalled receiver holds the output register; the back then waits
// at the emit step, the queue fills and in_ready drops.
// Reset (rst_n low, synchronous) empties the queue and the output register,
// closes any open period and clears the sums and last close.
// ----------------------------------------------------------------------------
module vwap_candle_aggregator #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_operation,
  input  wire logic [31:0] in_period_key,
  input  wire logic [31:0] in_price,
  input  wire logic [31:0] in_amount,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_candle_key,
  output logic [31:0]      out_candle_high,
  output logic [31:0]      out_candle_low,
  output logic [31:0]      out_candle_open,
  output logic [31:0]      out_candle_close,
  output logic             out_zero_volume
);
  import vca_pkg::*;

  fifo_stat_t q_stat;
  cmd_t       push_cmd, pop_cmd;
  logic       q_push, q_pop;

  // Classify entries and track the open period key
  vca_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_period_key (in_period_key),
    .in_price      (in_price),
    .in_amount     (in_amount),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  // Decouple intake from the slow close path
  vca_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .stat     (q_stat)
  );

  // Accumulate, divide and emit candles
  vca_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .q_cmd            (pop_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_candle_key   (out_candle_key),
    .out_candle_high  (out_candle_high),
    .out_candle_low   (out_candle_low),
    .out_candle_open  (out_candle_open),
    .out_candle_close (out_candle_close),
    .out_zero_volume  (out_zero_volume)
  );

`ifndef SYNTHESIS
  // Never push into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("push into full command queue");

  // Never pop from an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty command queue");

  // Reset leaves no candle pending
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("candle pending after reset");
`endif

endmodule : vwap_candle_aggregator
`default_nettype wire

>>> hdl/vca_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vca_front
// Accepts entries, tracks the open period key and classifies each entry.
// ----------------------------------------------------------------------------
module vca_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     in_operation,
  input  wire logic [31:0]              in_period_key,
  input  wire logic [31:0]              in_price,
  input  wire logic [31:0]              in_amount,
  input  vca_pkg::fifo_stat_t           q_stat,
  output logic                          q_push,
  output vca_pkg::cmd_t                 q_cmd
);
  import vca_pkg::*;

  logic             have_r, have_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic             accept;
  cmd_kind_t        kind;
  logic             keep;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    kind     = CMD_ACC;
    keep     = 1'b1;
    have_nxt = have_r;
    key_nxt  = key_r;
    if (in_operation) begin
      kind     = CMD_CLOSE;
      keep     = have_r;           // drop a flush with nothing open
      have_nxt = 1'b0;
    end else if (!have_r) begin
      kind     = CMD_OPEN;
      have_nxt = 1'b1;
      key_nxt  = in_period_key;
    end else if (in_period_key != key_r) begin
      kind     = CMD_CLOSE_OPEN;
      key_nxt  = in_period_key;
    end
  end

  assign q_push       = accept && keep;
  assign q_cmd.kind   = kind;
  assign q_cmd.key    = in_period_key;
  assign q_cmd.price  = in_price;
  assign q_cmd.amount = in_amount;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      key_r  <= '0;
    end else if (accept) begin
      have_r <= have_nxt;
      key_r  <= key_nxt;
    end
  end

endmodule : vca_front
`default_nettype wire

>>> hdl/vca_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vca_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module vca_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  vca_pkg::cmd_t       push_cmd,
  input  wire logic           pop,
  output vca_pkg::cmd_t       pop_cmd,
  output vca_pkg::fifo_stat_t stat
);
  import vca_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_cmd    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule : vca_fifo
`default_nettype wire

>>> hdl/vca_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vca_back
// Executes queued commands: accumulate, divide for VWAP, emit candles.
// ----------------------------------------------------------------------------
module vca_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  vca_pkg::fifo_stat_t      q_stat,
  input  vca_pkg::cmd_t            q_cmd,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [31:0]              out_candle_key,
  output logic [31:0]              out_candle_high,
  output logic [31:0]              out_candle_low,
  output logic [31:0]              out_candle_open,
  output logic [31:0]              out_candle_close,
  output logic                     out_zero_volume
);
  import vca_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT,
    ST_MUL,
    ST_ADD
  } state_t;

  state_t              state_r;
  cmd_t                cmd_r;
  logic [KEY_W-1:0]    cur_key_r;
  logic [VSUM_W-1:0]   vsum_r, vsum_nxt;
  logic [ASUM_W-1:0]   asum_r, asum_nxt;
  logic [PRICE_W-1:0]  high_r, high_nxt, low_r, low_nxt;
  logic [31:0]         last_close_r;
  logic                first_r;
  logic [VSUM_W-1:0]   prod_r;
  logic [VSUM_W-1:0]   quo_r;
  logic [ASUM_W-1:0]   rem_r, rem_nxt;
  logic [5:0]          cnt_r;
  logic                zv_r;
  logic                out_valid_r;
  logic [31:0]         o_key_r, o_high_r, o_low_r, o_open_r, o_close_r;
  logic                o_zv_r;

  logic                opening;
  logic [VSUM_W-1:0]   vbase;
  logic [VSUM_W:0]     vadd;
  logic [ASUM_W-1:0]   abase;
  logic [ASUM_W:0]     aadd;
  logic [ASUM_W:0]     rem_sh;
  logic [ASUM_W+1:0]   diff;
  logic                ge;
  logic [31:0]         vwap;
  logic [VSUM_W-1:0]   prod_nxt;
  logic                is_close;
  logic                out_free;
  logic                emit;

  assign q_pop    = (state_r == ST_IDLE) && !q_stat.empty;
  assign is_close = (q_cmd.kind == CMD_CLOSE) || (q_cmd.kind == CMD_CLOSE_OPEN);
  assign out_free = !out_valid_r || out_ready;
  assign emit     = (state_r == ST_EMIT) && !first_r && out_free;

  // Product of the trade, registered before the sum
  assign prod_nxt = cmd_r.price * cmd_r.amount;

  // Saturating accumulation; an opening trade starts from empty sums
  assign opening  = (cmd_r.kind != CMD_ACC);
  assign vbase    = opening ? '0 : vsum_r;
  assign vadd     = {1'b0, vbase} + {1'b0, prod_r};
  assign vsum_nxt = vadd[VSUM_W] ? '1 : vadd[VSUM_W-1:0];
  assign abase    = opening ? '0 : asum_r;
  assign aadd     = {1'b0, abase} + (ASUM_W + 1)'(cmd_r.amount);
  assign asum_nxt = aadd[ASUM_W] ? '1 : aadd[ASUM_W-1:0];
  assign high_nxt = (opening || cmd_r.price > high_r) ? cmd_r.price : high_r;
  assign low_nxt  = (opening || cmd_r.price < low_r)  ? cmd_r.price : low_r;

  // One quotient bit per cycle, restoring division
  assign rem_sh  = {rem_r, quo_r[VSUM_W-1]};
  assign diff    = {1'b0, rem_sh} - {2'b00, asum_r};
  assign ge      = !diff[ASUM_W+1];
  assign rem_nxt = ge ? diff[ASUM_W-1:0] : rem_sh[ASUM_W-1:0];

  // Saturate the quotient to Q16.16
  assign vwap = (quo_r[VSUM_W-1:32] != '0) ? '1 : quo_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      first_r      <= 1'b1;
      out_valid_r  <= 1'b0;
      vsum_r       <= '0;
      asum_r       <= '0;
      high_r       <= '0;
      low_r        <= '0;
      last_close_r <= '0;
      cur_key_r    <= '0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (!q_stat.empty) begin
            cmd_r <= q_cmd;
            if (is_close) begin
              rem_r <= '0;
              cnt_r <= '0;
              if (asum_r == '0) begin
                zv_r    <= 1'b1;
                quo_r   <= '0;
                state_r <= ST_EMIT;
              end else begin
                zv_r    <= 1'b0;
                quo_r   <= vsum_r;
                state_r <= ST_DIV;
              end
            end else begin
              state_r <= ST_MUL;
            end
          end
        end
        ST_DIV: begin
          rem_r <= rem_nxt;
          quo_r <= {quo_r[VSUM_W-2:0], ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == '1) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (first_r || out_free) begin
            if (!first_r) begin
              o_key_r     <= cur_key_r;
              o_high_r    <= high_r;
              o_low_r     <= low_r;
              o_open_r    <= last_close_r;
              o_close_r   <= vwap;
              o_zv_r      <= zv_r;
            end
            first_r      <= 1'b0;
            last_close_r <= vwap;
            state_r      <= (cmd_r.kind == CMD_CLOSE_OPEN) ? ST_MUL : ST_IDLE;
          end
        end
        ST_MUL: begin
          prod_r  <= prod_nxt;
          state_r <= ST_ADD;
        end
        ST_ADD: begin
          vsum_r  <= vsum_nxt;
          asum_r  <= asum_nxt;
          high_r  <= high_nxt;
          low_r   <= low_nxt;
          if (opening) begin
            cur_key_r <= cmd_r.key;
          end
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_candle_key   = o_key_r;
  assign out_candle_high  = o_high_r;
  assign out_candle_low   = o_low_r;
  assign out_candle_open  = o_open_r;
  assign out_candle_close = o_close_r;
  assign out_zero_volume  = o_zv_r;

endmodule : vca_back
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - candle aggregator testbench
// Sends trade and flush entries through vwap_candle_aggregator with random
// gaps on both channels and checks every candle, in order, against a
// cycle-free model of the period bookkeeping and the VWAP division.
// ----------------------------------------------------------------------------
module tb;
  import vca_pkg::*;

  // Entry operations (only bit 0 exists on the port)
  localparam logic OP_TRADE = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [ASUM_W-1:0] ASUM_MAX = '1;
  localparam int unsigned RANDOM_ENTRIES = 1050;
  // Covers a full queue of closes ahead of the last one
  localparam int unsigned DRAIN_CYCLES   = 400;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [PRICE_W-1:0] high;
    logic [PRICE_W-1:0] low;
    logic [PRICE_W-1:0] open_px;
    logic [PRICE_W-1:0] close_px;
    logic               zero_vol;
  } candle_t;

  typedef struct packed {
    logic               op;
    logic [KEY_W-1:0]   key;
    logic [PRICE_W-1:0] price;
    logic [AMT_W-1:0]   amount;
    logic               typed;   // use the candle below instead of the model
    candle_t            want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_operation;
  logic [31:0] in_period_key;
  logic [31:0] in_price;
  logic [31:0] in_amount;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_candle_key;
  logic [31:0] out_candle_high;
  logic [31:0] out_candle_low;
  logic [31:0] out_candle_open;
  logic [31:0] out_candle_close;
  logic        out_zero_volume;

  vwap_candle_aggregator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_period_key    (in_period_key),
    .in_price         (in_price),
    .in_amount        (in_amount),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_candle_key   (out_candle_key),
    .out_candle_high  (out_candle_high),
    .out_candle_low   (out_candle_low),
    .out_candle_open  (out_candle_open),
    .out_candle_close (out_candle_close),
    .out_zero_volume  (out_zero_volume)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Period bookkeeping model
  // --------------------------------------------------------------------------
  logic [KEY_W-1:0]   pr_key;
  logic               pr_open;     // a period is being accumulated
  logic               pr_first;    // next close only sets the open price
  logic [VSUM_W-1:0]  pr_vsum;     // Q32.32 sum of price*amount
  logic [ASUM_W-1:0]  pr_asum;     // Q32.16 sum of amounts
  logic [PRICE_W-1:0] pr_high;
  logic [PRICE_W-1:0] pr_low;
  logic [PRICE_W-1:0] pr_last;     // VWAP of the last closed period

  candle_t candle_q[$];            // candles still owed by the block
  int unsigned errors;

  // Fold one trade into the sums; both sums clamp instead of wrapping
  function automatic void add_trade(input logic [31:0] price, input logic [31:0] amount);
    logic [VSUM_W:0] vs;
    logic [ASUM_W:0] as;
    vs = {1'b0, pr_vsum} + (64'(price) * 64'(amount));
    pr_vsum = vs[VSUM_W] ? '1 : vs[VSUM_W-1:0];
    as = {1'b0, pr_asum} + (ASUM_W + 1)'(amount);
    pr_asum = (as > {1'b0, ASUM_MAX}) ? ASUM_MAX : as[ASUM_W-1:0];
    if (price > pr_high) pr_high = price;
    if (price < pr_low) pr_low = price;
  endfunction

  // The opening trade counts and seeds high and low
  function automatic void start_period(input logic [31:0] key, input logic [31:0] price,
                                       input logic [31:0] amount);
    pr_key  = key;
    pr_open = 1'b1;
    pr_vsum = '0;
    pr_asum = '0;
    pr_high = price;
    pr_low  = price;
    add_trade(price, amount);
  endfunction

  // Close the open period; the very first close emits nothing
  function automatic bit finish_period(output candle_t c);
    logic [VSUM_W-1:0]  q;
    logic [PRICE_W-1:0] vwap;
    vwap = '0;
    if (pr_asum != '0) begin
      q    = pr_vsum / 64'(pr_asum);
      vwap = (q > 64'h0000_0000_FFFF_FFFF) ? '1 : q[31:0];
    end
    pr_open = 1'b0;
    c = '{pr_key, pr_high, pr_low, pr_last, vwap, (pr_asum == '0)};
    pr_last = vwap;
    if (pr_first) begin
      pr_first = 1'b0;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit predict_candle(input logic op, input logic [31:0] key,
                                        input logic [31:0] price, input logic [31:0] amount,
                                        output candle_t c);
    bit emitted;
    emitted = 1'b0;
    c = '0;
    if (op == OP_FLUSH) begin
      // Flush fields are don't-care; a flush with nothing open is dropped
      if (pr_open) emitted = finish_period(c);
    end else if (!pr_open) begin
      start_period(key, price, amount);
    end else if (key == pr_key) begin
      add_trade(price, amount);
    end else begin
      emitted = finish_period(c);
      start_period(key, price, amount);
    end
    return emitted;
  endfunction

  // --------------------------------------------------------------------------
  // Entry driver: drive at the falling edge, sample the transfer at the rising
  // --------------------------------------------------------------------------
  bit send_idle;

  task automatic send_entry(input logic op, input logic [31:0] key, input logic [31:0] price,
                            input logic [31:0] amount, input logic typed, input candle_t want);
    int unsigned gap;
    candle_t     c;
    gap = send_idle ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    // Drop valid only when a gap is drawn, so back-to-back entries keep it high
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_period_key <= key;
    in_price      <= price;
    in_amount     <= amount;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (predict_candle(op, key, price, amount, c)) candle_q = {candle_q, (typed ? want : c)};
  endtask

  // Hold the input side until every owed candle has been taken
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (candle_q.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Candle receiver: stall a random number of cycles after each transfer
  // --------------------------------------------------------------------------
  bit          recv_idle;
  int unsigned ready_hold;
  int unsigned recv_count;
  candle_t     mon_got;
  candle_t     mon_want;

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      out_ready  <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic note_mismatch(input string what, input candle_t want, input candle_t got);
    errors++;
    if (errors <= 10) begin
      $display("%s: expected key=%h high=%h low=%h open=%h close=%h zv=%b", what,
               want.key, want.high, want.low, want.open_px, want.close_px, want.zero_vol);
      $display("%s:   actual key=%h high=%h low=%h open=%h close=%h zv=%b", what,
               got.key, got.high, got.low, got.open_px, got.close_px, got.zero_vol);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      mon_got = '{out_candle_key, out_candle_high, out_candle_low, out_candle_open,
                  out_candle_close, out_zero_volume};
      ready_hold <= recv_idle ? $urandom_range(0, 7) : 0;
      recv_count++;
      // Switch between stalling and a full-rate stretch now and then
      if (recv_count % 32 == 0) recv_idle = ($urandom_range(0, 2) != 0);
      if (candle_q.size() == 0) begin
        note_mismatch("unexpected candle", '0, mon_got);
      end else begin
        mon_want = candle_q.pop_front();
        if (mon_got !== mon_want) note_mismatch("candle mismatch", mon_want, mon_got);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed entries. Typed candles are the ones that can be worked out by
  // hand; the rest come from the model.
  // --------------------------------------------------------------------------
  stim_row_t dir_tab [18] = '{
    // flush with nothing open: dropped
    '{OP_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
    // first period with zero volume, closed by flush: open price becomes 0
    '{OP_TRADE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{OP_FLUSH, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{OP_FLUSH, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    // max price and amount twice: value sum clamps at 2^64-1
    '{OP_TRADE, 32'h0000_0005, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{OP_TRADE, 32'h0000_0005, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{OP_TRADE, 32'h0000_0005, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{OP_FLUSH, 32'h1234_5678, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
      '{32'h0000_0005, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1'b0}},
    // zero-volume period closed by a key change
    '{OP_TRADE, 32'h0000_0007, 32'h0001_0000, 32'h0000_0000, 1'b0, '0},
    '{OP_TRADE, 32'h0000_0007, 32'h0002_0000, 32'h0000_0000, 1'b0, '0},
    '{OP_TRADE, 32'h0000_0008, 32'h1234_5678, 32'h0001_0000, 1'b1,
      '{32'h0000_0007, 32'h0002_0000, 32'h0001_0000, 32'h8000_0000, 32'h0000_0000, 1'b1}},
    '{OP_TRADE, 32'h0000_0008, 32'h0000_1000, 32'h0001_0000, 1'b0, '0},
    '{OP_TRADE, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 1'b0, '0},
    // flush carries junk fields
    '{OP_FLUSH, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
    // same key as the flushed period still opens a new one
    '{OP_TRADE, 32'hFFFF_FFFF, 32'h0000_0003, 32'h0000_0002, 1'b0, '0},
    '{OP_TRADE, 32'h0000_0000, 32'h0000_0005, 32'hFFFF_FFFF, 1'b1,
      '{32'hFFFF_FFFF, 32'h0000_0003, 32'h0000_0003, 32'h0000_0001, 32'h0000_0003, 1'b0}},
    '{OP_FLUSH, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1,
      '{32'h0000_0000, 32'h0000_0005, 32'h0000_0005, 32'h0000_0003, 32'h0000_0005, 1'b0}},
    '{OP_FLUSH, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, '0}
  };

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    logic [31:0] r_key;
    logic [31:0] r_price;
    logic [31:0] r_amt;
    logic [31:0] base;
    int unsigned roll;

    in_valid      = 1'b0;
    in_operation  = OP_TRADE;
    in_period_key = '0;
    in_price      = '0;
    in_amount     = '0;
    out_ready     = 1'b0;
    rst_n         = 1'b0;
    send_idle     = 1'b1;
    recv_idle     = 1'b1;
    ready_hold    = 0;
    recv_count    = 0;
    errors        = 0;

    pr_key   = '0;
    pr_open  = 1'b0;
    pr_first = 1'b1;
    pr_vsum  = '0;
    pr_asum  = '0;
    pr_high  = '0;
    pr_low   = '0;
    pr_last  = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      send_entry(dir_tab[i].op, dir_tab[i].key, dir_tab[i].price, dir_tab[i].amount,
                 dir_tab[i].typed, dir_tab[i].want);
    end
    wait_drained();

    // Random runs of trades sharing a key, key changes and some flushes
    r_key = $urandom;
    base  = $urandom;
    for (int n = 0; n < RANDOM_ENTRIES; n++) begin
      if (n % 64 == 0) send_idle = ($urandom_range(0, 3) != 0);
      if (n == RANDOM_ENTRIES / 2) wait_drained();

      case ($urandom_range(0, 9))
        0:       r_price = '0;
        1:       r_price = '1;
        2, 3:    r_price = $urandom;
        default: r_price = base + 32'($urandom_range(0, 4095)) - 32'd2048;
      endcase
      case ($urandom_range(0, 9))
        0:       r_amt = '0;
        1:       r_amt = '1;
        2, 3:    r_amt = $urandom;
        default: r_amt = $urandom_range(1, 32'h0004_0000);
      endcase

      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        send_entry(OP_FLUSH, $urandom, $urandom, $urandom, 1'b0, '0);
      end else begin
        if (roll < 35) begin
          // Advance to a new period key
          case ($urandom_range(0, 2))
            0:       r_key = $urandom;
            1:       r_key = r_key + 1;
            default: r_key = r_key ^ (32'd1 << $urandom_range(0, 31));
          endcase
          base = $urandom;
        end
        send_entry(OP_TRADE, r_key, r_price, r_amt, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && candle_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
